// File: rtl/adaptive_proposal_scale_tuner_assert.svh
// assertion macros for the proposal scale tuner
// expects clk and arst_n in the scope where the macros are used
`ifndef ADAPTIVE_PROPOSAL_SCALE_TUNER_ASSERT_SVH
`define ADAPTIVE_PROPOSAL_SCALE_TUNER_ASSERT_SVH

// same-cycle implication
`define APS_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("aps assertion failed");

// next-cycle implication
`define APS_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("aps assertion failed");

`endif

// File: rtl/aps_pkg.sv
// shared types, constants and datapath command codes of the proposal scale tuner
// no dependencies
package aps_pkg;

	// input transfer payload
	typedef struct packed {
		logic [5:0]  group_index;
		logic [15:0] acceptance_level;
		logic [31:0] width_value;
		logic        value_present;
		logic        last_element;
	} item_t;

	// result transfer payload
	typedef struct packed {
		logic [31:0] scaled_width;
		logic        saturated;
		logic        run_last;
	} result_t;

	// configuration register indexes
	typedef enum logic [1:0] {
		CFG_TARGET   = 2'd0,
		CFG_ALPHA    = 2'd1,
		CFG_GAIN_NUM = 2'd2,
		CFG_T0       = 2'd3
	} cfg_idx_t;

	localparam logic [15:0] TARGET_RST = 16'd15335;
	localparam logic [16:0] ALPHA_RST  = 17'd39322;
	localparam logic [23:0] GNUM_RST   = 24'd65536;
	localparam logic [23:0] T0_RST     = 24'd256;

	localparam logic [31:0] GAIN_MAX   = 32'h00FF_FFFF;
	localparam logic [31:0] SCALE_MAX  = 32'hFFFF_FFFF;
	localparam logic [16:0] LOG2E_Q16  = 17'd94548;
	localparam logic [22:0] LG_BIAS_C  = 23'd1048576;
	localparam logic [22:0] LG_BIAS_X  = 23'd524288;
	localparam logic [30:0] Q30_ONE    = 31'h4000_0000;

	// datapath micro-operations
	typedef enum logic [4:0] {
		OP_NONE,
		OP_CLR,
		OP_LOAD,
		OP_RDCNT,
		OP_WRINC,
		OP_X,
		OP_GMAX,
		OP_GZERO,
		OP_LD_C,
		OP_NORM,
		OP_MANT,
		OP_SQ,
		OP_LC_LDX,
		OP_AX,
		OP_LGAIN,
		OP_ROOT,
		OP_PFIN_G,
		OP_DELTA,
		OP_DL,
		OP_DH,
		OP_ESUM,
		OP_PFIN_S,
		OP_MULW
	} dp_op_t;

	typedef struct packed {
		dp_op_t     op;
		logic [3:0] step;
	} dp_cmd_t;

	typedef struct packed {
		logic x_zero;
		logic c_zero;
		logic clr_done;
	} dp_stat_t;

	// q1.30 root 2^(2^-(k+1)), each one the truncated square root of the one before
	function automatic logic [30:0] root_q30(input int unsigned k);
		logic [63:0] prev;
		logic [63:0] v;
		logic [63:0] r;
		logic [63:0] bv;
		prev = 64'd1 << 31;
		for (int unsigned j = 0; j <= k; j++) begin
			v  = prev << 30;
			r  = '0;
			bv = 64'd1 << 62;
			for (int i = 0; i < 32; i++) begin
				if (v >= r + bv) begin
					v = v - (r + bv);
					r = (r >> 1) + bv;
				end else begin
					r = r >> 1;
				end
				bv = bv >> 2;
			end
			prev = r;
		end
		return prev[30:0];
	endfunction

endpackage

// File: rtl/adaptive_proposal_scale_tuner.sv
// top level of the proposal scale tuner: sequencer plus datapath
// depends on aps_pkg, aps_ctrl, aps_dpath and the assertion macro header
//
// Usage:
//   item channel (item_valid/item_stall/item) carries proposal widths of a run for
//   one group; result channel (result_valid/result_stall/result) returns one scaled
//   width per item that carries a width. Items without a width give no result.
//   The first width of a run computes the run's scale with two 16-step log2 squarings
//   and two 16-step power of two root chains that share one 33x33 multiplier; when
//   the gain is forced to zero or to its cap, the log2 and gain root chain are skipped.
//   Later widths of the run take one multiply each. An item that ends a run adds the
//   count read-modify-write, which is all an empty end-of-run item does.
//   After reset the update count memory is swept to zero, one group per cycle, with
//   item_stall high; configuration writes are taken. A stalled result sits in the
//   output register; the block still takes the next item and holds its result back
//   only until the register is free. The user must write configuration through
//   wr_en/wr_index/wr_data only while the block is idle; the block does not check.
module adaptive_proposal_scale_tuner import aps_pkg::*; #(
	parameter int NUM_GROUPS = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        item_valid,
	output logic        item_stall,
	input  item_t       item,
	output logic        result_valid,
	input  logic        result_stall,
	output result_t     result,
	input  logic        wr_en,
	input  logic [1:0]  wr_index,
	input  logic [23:0] wr_data
);

	dp_cmd_t  cmd;
	dp_stat_t stat;

	// sequencer
	aps_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.present      (item.value_present),
		.last         (item.last_element),
		.item_stall   (item_stall),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.cmd          (cmd),
		.stat         (stat)
	);

	// datapath
	aps_dpath #(
		.NUM_GROUPS (NUM_GROUPS)
	) u_dpath (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.stat     (stat),
		.item     (item),
		.wr_en    (wr_en),
		.wr_index (wr_index),
		.wr_data  (wr_data),
		.result   (result)
	);

	// checks
	`include "adaptive_proposal_scale_tuner_assert.svh"

	`APS_ASSERT_NXT(a_busy_after_work, item_valid && !item_stall && (item.value_present || item.last_element), item_stall)
	`APS_ASSERT_IMP(a_result_from_mul, $rose(result_valid), $past(cmd.op == OP_MULW))
	`APS_ASSERT_IMP(a_inc_after_read, cmd.op == OP_WRINC, $past(cmd.op == OP_RDCNT))

endmodule

// File: rtl/aps_ctrl.sv
// sequencer of the proposal scale tuner: handshakes and datapath commands
// depends on aps_pkg
module aps_ctrl import aps_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     item_valid,
	input  logic     present,
	input  logic     last,
	output logic     item_stall,
	output logic     result_valid,
	input  logic     result_stall,
	output dp_cmd_t  cmd,
	input  dp_stat_t stat
);

	typedef enum logic [4:0] {
		S_CLEAR, S_IDLE, S_RDCNT, S_X, S_CHK,
		S_NORM_C, S_MANT_C, S_SQ_C, S_LC,
		S_NORM_X, S_MANT_X, S_SQ_X, S_AX, S_LGAIN,
		S_ROOT_G, S_PFIN_G, S_DELTA, S_DL, S_DH, S_ESUM,
		S_ROOT_S, S_PFIN_S, S_MULW, S_INC_RD, S_INC_WR
	} state_t;

	state_t     state_q;
	logic [3:0] step_q;
	logic       in_run_q;
	logic       last_q;
	logic       valid_q;
	logic       out_free;

	assign out_free     = !valid_q || !result_stall;
	assign item_stall   = (state_q != S_IDLE);
	assign result_valid = valid_q;

	// command decode
	always_comb begin
		cmd.step = step_q;
		unique case (state_q)
			S_CLEAR:            cmd.op = OP_CLR;
			S_IDLE:             cmd.op = OP_LOAD;
			S_RDCNT, S_INC_RD:  cmd.op = OP_RDCNT;
			S_X:                cmd.op = OP_X;
			S_CHK:              cmd.op = stat.x_zero ? OP_GMAX :
			                             (stat.c_zero ? OP_GZERO : OP_LD_C);
			S_NORM_C, S_NORM_X: cmd.op = OP_NORM;
			S_MANT_C, S_MANT_X: cmd.op = OP_MANT;
			S_SQ_C, S_SQ_X:     cmd.op = OP_SQ;
			S_LC:               cmd.op = OP_LC_LDX;
			S_AX:               cmd.op = OP_AX;
			S_LGAIN:            cmd.op = OP_LGAIN;
			S_ROOT_G, S_ROOT_S: cmd.op = OP_ROOT;
			S_PFIN_G:           cmd.op = OP_PFIN_G;
			S_DELTA:            cmd.op = OP_DELTA;
			S_DL:               cmd.op = OP_DL;
			S_DH:               cmd.op = OP_DH;
			S_ESUM:             cmd.op = OP_ESUM;
			S_PFIN_S:           cmd.op = OP_PFIN_S;
			S_MULW:             cmd.op = out_free ? OP_MULW : OP_NONE;
			S_INC_WR:           cmd.op = OP_WRINC;
			default:            cmd.op = OP_NONE;
		endcase
	end

	// state and registered outputs
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_CLEAR;
			step_q   <= '0;
			in_run_q <= 1'b0;
			last_q   <= 1'b0;
			valid_q  <= 1'b0;
		end else begin
			if (valid_q && !result_stall)
				valid_q <= 1'b0;
			unique case (state_q)
				S_CLEAR: begin
					if (stat.clr_done)
						state_q <= S_IDLE;
				end
				S_IDLE: begin
					if (item_valid) begin
						last_q <= last;
						if (present) begin
							state_q <= in_run_q ? S_MULW : S_RDCNT;
						end else if (last) begin
							in_run_q <= 1'b0;
							state_q  <= S_INC_RD;
						end
					end
				end
				S_RDCNT: state_q <= S_X;
				S_X:     state_q <= S_CHK;
				S_CHK: begin
					step_q  <= '0;
					state_q <= (stat.x_zero || stat.c_zero) ? S_DELTA : S_NORM_C;
				end
				S_NORM_C: begin
					step_q <= (step_q == 4'd5) ? 4'd0 : step_q + 4'd1;
					if (step_q == 4'd5)
						state_q <= S_MANT_C;
				end
				S_MANT_C: state_q <= S_SQ_C;
				S_SQ_C: begin
					step_q <= step_q + 4'd1;
					if (step_q == 4'd15)
						state_q <= S_LC;
				end
				S_LC: state_q <= S_NORM_X;
				S_NORM_X: begin
					step_q <= (step_q == 4'd5) ? 4'd0 : step_q + 4'd1;
					if (step_q == 4'd5)
						state_q <= S_MANT_X;
				end
				S_MANT_X: state_q <= S_SQ_X;
				S_SQ_X: begin
					step_q <= step_q + 4'd1;
					if (step_q == 4'd15)
						state_q <= S_AX;
				end
				S_AX:    state_q <= S_LGAIN;
				S_LGAIN: state_q <= S_ROOT_G;
				S_ROOT_G: begin
					step_q <= step_q + 4'd1;
					if (step_q == 4'd15)
						state_q <= S_PFIN_G;
				end
				S_PFIN_G: state_q <= S_DELTA;
				S_DELTA:  state_q <= S_DL;
				S_DL:     state_q <= S_DH;
				S_DH:     state_q <= S_ESUM;
				S_ESUM:   state_q <= S_ROOT_S;
				S_ROOT_S: begin
					step_q <= step_q + 4'd1;
					if (step_q == 4'd15)
						state_q <= S_PFIN_S;
				end
				S_PFIN_S: state_q <= S_MULW;
				S_MULW: begin
					if (out_free) begin
						valid_q  <= 1'b1;
						in_run_q <= !last_q;
						state_q  <= last_q ? S_INC_RD : S_IDLE;
					end
				end
				S_INC_RD: state_q <= S_INC_WR;
				S_INC_WR: state_q <= S_IDLE;
				default:  state_q <= S_IDLE;
			endcase
		end
	end

endmodule

// File: rtl/aps_dpath.sv
// datapath of the proposal scale tuner: count memory, registers, shared multiplier
// depends on aps_pkg
module aps_dpath import aps_pkg::*; #(
	parameter int NUM_GROUPS = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  dp_cmd_t     cmd,
	output dp_stat_t    stat,
	input  item_t       item,
	input  logic        wr_en,
	input  logic [1:0]  wr_index,
	input  logic [23:0] wr_data,
	output result_t     result
);

	localparam int AW = (NUM_GROUPS > 1) ? $clog2(NUM_GROUPS) : 1;
	localparam logic [30:0] ROOTS [16] = '{
		root_q30(0),  root_q30(1),  root_q30(2),  root_q30(3),
		root_q30(4),  root_q30(5),  root_q30(6),  root_q30(7),
		root_q30(8),  root_q30(9),  root_q30(10), root_q30(11),
		root_q30(12), root_q30(13), root_q30(14), root_q30(15)
	};

	// configuration
	logic [15:0] target_q;
	logic [16:0] alpha_q;
	logic [23:0] gnum_q;
	logic [23:0] t0_q;

	// item and count storage
	logic [AW-1:0] clr_q;
	logic [AW-1:0] grp_q;
	logic [AW-1:0] grp_mod;
	logic [18:0]   rem;
	logic [15:0]   acc_q;
	logic [31:0]   width_q;
	logic          last_q;
	logic [31:0]   cnt_mem [NUM_GROUPS];
	logic [31:0]   cnt_q;

	// run computation
	logic [40:0]        x_q;
	logic [63:0]        v_q;
	logic [5:0]         n_q;
	logic [30:0]        m_q;
	logic [15:0]        fr_q;
	logic [22:0]        lc_q;
	logic signed [40:0] ax_q;
	logic [33:0]        e_q;
	logic [23:0]        gain_q;
	logic [31:0]        scale_q;
	logic               clip_q;
	logic signed [41:0] delta_q;
	logic [40:0]        pl_q;
	logic signed [34:0] ph_q;
	result_t            res_q;

	// combinational helpers
	logic signed [32:0] mul_a;
	logic signed [32:0] mul_b;
	logic signed [65:0] mul_p;
	logic [6:0]         nsft;
	logic               top_zero;
	logic [31:0]        sq_t;
	logic [21:0]        lgv;
	logic [22:0]        lc_n;
	logic [22:0]        lx;
	logic [16:0]        diff;
	logic [15:0]        frac;
	logic signed [63:0] esum;
	logic signed [33:0] ip;
	logic signed [33:0] sh;
	logic signed [33:0] nsh;
	logic [47:0]        pw_r;
	logic [31:0]        maxv;
	logic [31:0]        pw_val;
	logic               pw_clip;
	logic [47:0]        prod;
	logic               prod_sat;

	assign stat.x_zero   = (x_q == '0);
	assign stat.c_zero   = (gnum_q == '0);
	assign stat.clr_done = (clr_q == AW'(NUM_GROUPS - 1));
	assign result        = res_q;

	// group index folded into the table range
	always_comb begin
		rem = {13'b0, item.group_index};
		for (int k = 5; k >= 0; k--) begin
			if (rem >= (19'(NUM_GROUPS) << k))
				rem = rem - (19'(NUM_GROUPS) << k);
		end
		grp_mod = rem[AW-1:0];
	end

	// log2 and normalize helpers
	assign nsft     = 7'd32 >> cmd.step;
	assign top_zero = ((v_q >> (7'd64 - nsft)) == '0);
	assign sq_t     = mul_p[61:30];
	assign lgv      = {n_q, fr_q};
	assign lc_n     = {1'b0, lgv} - LG_BIAS_C;
	assign lx       = {1'b0, lgv} - LG_BIAS_X;
	assign diff     = {1'b0, acc_q} - {1'b0, target_q};
	assign frac     = e_q[15:0];
	assign esum     = ($signed({{29{ph_q[34]}}, ph_q}) <<< 24) + $signed({23'b0, pl_q});
	assign prod     = mul_p[63:16];
	assign prod_sat = |prod[47:32];

	// shared multiplier operand select
	always_comb begin
		unique case (cmd.op)
			OP_SQ: begin
				mul_a = {2'b0, m_q};
				mul_b = {2'b0, m_q};
			end
			OP_ROOT: begin
				mul_a = {2'b0, m_q};
				mul_b = {2'b0, ROOTS[cmd.step]};
			end
			OP_AX: begin
				mul_a = {16'b0, alpha_q};
				mul_b = {{10{lx[22]}}, lx};
			end
			OP_DELTA: begin
				mul_a = {9'b0, gain_q};
				mul_b = {{16{diff[16]}}, diff};
			end
			OP_DL: begin
				mul_a = {9'b0, delta_q[23:0]};
				mul_b = {16'b0, LOG2E_Q16};
			end
			OP_DH: begin
				mul_a = {{15{delta_q[41]}}, delta_q[41:24]};
				mul_b = {16'b0, LOG2E_Q16};
			end
			OP_MULW: begin
				mul_a = {1'b0, width_q};
				mul_b = {1'b0, scale_q};
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	assign mul_p = mul_a * mul_b;

	// power of two finish: integer shift and cap
	always_comb begin
		ip      = $signed(e_q) >>> 16;
		sh      = ip - 34'sd14;
		nsh     = -sh;
		maxv    = (cmd.op == OP_PFIN_G) ? GAIN_MAX : SCALE_MAX;
		pw_r    = '0;
		pw_clip = 1'b0;
		pw_val  = maxv;
		if (ip >= 34'sd32) begin
			pw_clip = 1'b1;
		end else begin
			if (sh >= 34'sd0)
				pw_r = {17'b0, m_q} << sh[4:0];
			else if (sh < -34'sd31)
				pw_r = '0;
			else
				pw_r = {17'b0, m_q} >> nsh[4:0];
			if (pw_r > {16'b0, maxv})
				pw_clip = 1'b1;
			else
				pw_val = pw_r[31:0];
		end
	end

	// configuration and clear pointer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			target_q <= TARGET_RST;
			alpha_q  <= ALPHA_RST;
			gnum_q   <= GNUM_RST;
			t0_q     <= T0_RST;
			clr_q    <= '0;
		end else begin
			if (wr_en) begin
				unique case (wr_index)
					CFG_TARGET:   target_q <= wr_data[15:0];
					CFG_ALPHA:    alpha_q  <= wr_data[16:0];
					CFG_GAIN_NUM: gnum_q   <= wr_data;
					CFG_T0:       t0_q     <= wr_data;
					default:      ;
				endcase
			end
			if (cmd.op == OP_CLR)
				clr_q <= clr_q + AW'(1);
		end
	end

	// update count memory, one write and one registered read
	always_ff @(posedge clk) begin
		if (cmd.op == OP_CLR)
			cnt_mem[clr_q] <= '0;
		else if (cmd.op == OP_WRINC)
			cnt_mem[grp_q] <= cnt_q + 32'd1;
		if (cmd.op == OP_RDCNT)
			cnt_q <= cnt_mem[grp_q];
	end

	// datapath registers
	always_ff @(posedge clk) begin
		unique case (cmd.op)
			OP_LOAD: begin
				grp_q   <= grp_mod;
				acc_q   <= item.acceptance_level;
				width_q <= item.width_value;
				last_q  <= item.last_element;
			end
			OP_X: begin
				x_q    <= {1'b0, cnt_q, 8'b0} + {17'b0, t0_q};
				clip_q <= 1'b0;
			end
			OP_GMAX: begin
				gain_q <= GAIN_MAX[23:0];
				clip_q <= 1'b1;
			end
			OP_GZERO: gain_q <= '0;
			OP_LD_C: begin
				v_q <= {40'b0, gnum_q};
				n_q <= 6'd63;
			end
			OP_NORM: begin
				if (top_zero) begin
					v_q <= v_q << nsft;
					n_q <= n_q - nsft[5:0];
				end
			end
			OP_MANT: begin
				m_q  <= v_q[63:33];
				fr_q <= '0;
			end
			OP_SQ: begin
				if (sq_t[31]) begin
					m_q  <= sq_t[31:1];
					fr_q <= {fr_q[14:0], 1'b1};
				end else begin
					m_q  <= sq_t[30:0];
					fr_q <= {fr_q[14:0], 1'b0};
				end
			end
			OP_LC_LDX: begin
				lc_q <= lc_n;
				v_q  <= {23'b0, x_q};
				n_q  <= 6'd63;
			end
			OP_AX: ax_q <= mul_p[40:0];
			OP_LGAIN: begin
				e_q <= {{11{lc_q[22]}}, lc_q} - {{9{ax_q[40]}}, ax_q[40:16]};
				m_q <= Q30_ONE;
			end
			OP_ROOT: begin
				if (frac[4'd15 - cmd.step])
					m_q <= mul_p[60:30];
			end
			OP_PFIN_G: begin
				gain_q <= pw_val[23:0];
				clip_q <= clip_q | pw_clip;
			end
			OP_DELTA: delta_q <= mul_p[41:0];
			OP_DL:    pl_q    <= mul_p[40:0];
			OP_DH:    ph_q    <= mul_p[34:0];
			OP_ESUM: begin
				e_q <= {{2{esum[63]}}, esum[63:32]};
				m_q <= Q30_ONE;
			end
			OP_PFIN_S: begin
				scale_q <= pw_val;
				clip_q  <= clip_q | pw_clip;
			end
			OP_MULW: begin
				res_q.scaled_width <= prod_sat ? SCALE_MAX : prod[31:0];
				res_q.saturated    <= clip_q | prod_sat;
				res_q.run_last     <= last_q;
			end
			default: ;
		endcase
	end

endmodule

// File: dv/tb.sv
// testbench for the adaptive proposal scale tuner: random and directed runs of widths
// depends on aps_pkg and the adaptive_proposal_scale_tuner rtl
`timescale 1ns / 100ps

module tb;
	import aps_pkg::*;

	// expected scaled widths, worked out from the group counts and the run's scale
	class scale_tuner_scoreboard;
		bit [31:0] group_count [64];
		bit [31:0] run_scale;
		bit        run_open;
		bit        run_clip;
		bit [15:0] target;
		bit [16:0] alpha;
		bit [23:0] gain_num;
		bit [23:0] t0;
		longint unsigned roots [16];
		result_t   pending_q [$];
		int        mismatches;

		function new();
			longint unsigned prev;
			foreach (group_count[i]) group_count[i] = '0;
			run_scale = '0;
			run_open = 0;
			run_clip = 0;
			target = TARGET_RST;
			alpha = ALPHA_RST;
			gain_num = GNUM_RST;
			t0 = T0_RST;
			mismatches = 0;
			prev = 64'd2 << 30;
			for (int k = 0; k < 16; k++) begin
				prev = int_sqrt(prev << 30);
				roots[k] = prev;
			end
		endfunction

		function longint unsigned int_sqrt(longint unsigned v);
			longint unsigned r;
			longint unsigned b;
			r = 0;
			b = 64'd1 << 62;
			while (b > v) b = b >> 2;
			while (b != 0) begin
				if (v >= r + b) begin
					v = v - (r + b);
					r = (r >> 1) + b;
				end else begin
					r = r >> 1;
				end
				b = b >> 2;
			end
			return r;
		endfunction

		// log2 in q.16 by repeated squaring of the q1.30 mantissa
		function longint log2_q16(longint unsigned v);
			int n;
			longint unsigned m;
			longint fr;
			n = 63;
			while (!v[n]) n--;
			m = (n >= 30) ? (v >> (n - 30)) : (v << (30 - n));
			fr = 0;
			for (int i = 0; i < 16; i++) begin
				m = (m * m) >> 30;
				fr = fr << 1;
				if (m >= (64'd2 << 30)) begin
					m = m >> 1;
					fr = fr | 1;
				end
			end
			return longint'(n) * 65536 + fr;
		endfunction

		// 2^(e/65536) in q.16 from the root chain, capped at maxv
		function longint unsigned exp2_q16(longint e, longint unsigned maxv, inout bit clip);
			longint ip;
			longint sh;
			longint unsigned f;
			longint unsigned m;
			longint unsigned r;
			ip = e >>> 16;
			f = e & 64'hFFFF;
			if (ip >= 32) begin
				clip = 1;
				return maxv;
			end
			m = 64'd1 << 30;
			for (int k = 0; k < 16; k++)
				if (f[15 - k]) m = (m * roots[k]) >> 30;
			sh = ip - 14;
			if (sh >= 0) r = m << sh;
			else if (sh <= -63) r = 0;
			else r = m >> (-sh);
			if (r > maxv) begin
				clip = 1;
				r = maxv;
			end
			return r;
		endfunction

		function void set_reg(cfg_idx_t idx, bit [23:0] d);
			case (idx)
				CFG_TARGET:   target = d[15:0];
				CFG_ALPHA:    alpha = d[16:0];
				CFG_GAIN_NUM: gain_num = d;
				CFG_T0:       t0 = d;
			endcase
		endfunction

		// gain and scale for a run opened on this group
		function void open_run(int g, bit [15:0] acc);
			bit clip;
			longint unsigned x;
			longint unsigned gain;
			longint lc;
			longint lx;
			longint delta;
			clip = 0;
			x = longint'(group_count[g]) * 256 + t0;
			if (x == 0) begin
				gain = GAIN_MAX;
				clip = 1;
			end else if (gain_num == 0) begin
				gain = 0;
			end else begin
				lc = log2_q16(gain_num) - 16 * 65536;
				lx = log2_q16(x) - 8 * 65536;
				gain = exp2_q16(lc - ((longint'(alpha) * lx) >>> 16), GAIN_MAX, clip);
			end
			delta = longint'(gain) * (longint'(acc) - longint'(target));
			run_scale = 32'(exp2_q16((delta * 94548) >>> 32, SCALE_MAX, clip));
			run_clip = clip;
			run_open = 1;
		endfunction

		function void note_item(item_t it);
			int g;
			longint unsigned prod;
			result_t r;
			g = int'(it.group_index);
			if (!it.value_present) begin
				if (it.last_element) begin
					group_count[g]++;
					run_open = 0;
					run_clip = 0;
				end
				return;
			end
			if (!run_open) open_run(g, it.acceptance_level);
			prod = (longint'(it.width_value) * longint'(run_scale)) >> 16;
			r.saturated = run_clip;
			if (prod > SCALE_MAX) begin
				prod = SCALE_MAX;
				r.saturated = 1;
			end
			r.scaled_width = prod[31:0];
			r.run_last = it.last_element;
			pending_q.push_back(r);
			if (it.last_element) begin
				group_count[g]++;
				run_open = 0;
				run_clip = 0;
			end
		endfunction

		function void check_result(result_t got);
			result_t exp_r;
			if (pending_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result: width %h sat %b last %b",
						got.scaled_width, got.saturated, got.run_last);
				return;
			end
			exp_r = pending_q.pop_front();
			if (got.scaled_width !== exp_r.scaled_width || got.saturated !== exp_r.saturated
					|| got.run_last !== exp_r.run_last) begin
				mismatches++;
				if (mismatches <= 10)
					$display("result mismatch: expected width %h sat %b last %b, got %h %b %b",
						exp_r.scaled_width, exp_r.saturated, exp_r.run_last,
						got.scaled_width, got.saturated, got.run_last);
			end
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        item_valid;
	logic        item_stall;
	item_t       item;
	logic        result_valid;
	logic        result_stall;
	result_t     result;
	logic        wr_en;
	logic [1:0]  wr_index;
	logic [23:0] wr_data;

	scale_tuner_scoreboard sb;
	int tx_idle;
	int rx_idle;

	adaptive_proposal_scale_tuner dut (
		.clk(clk),
		.arst_n(arst_n),
		.item_valid(item_valid),
		.item_stall(item_stall),
		.item(item),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.result(result),
		.wr_en(wr_en),
		.wr_index(wr_index),
		.wr_data(wr_data)
	);

	// clock
	initial begin
		clk = 0;
		forever #4 clk = ~clk;
	end

	// run limit
	initial begin
		#20_000_000;
		$display("simulation failed");
		$finish;
	end

	// result side: check accepted transfers, then pick the next stall
	always @(posedge clk) begin
		if (arst_n && result_valid && !result_stall) sb.check_result(result);
		result_stall <= ($urandom_range(99) < rx_idle);
	end

	// one input transfer, with an optional idle gap ahead of it
	task automatic send_item(item_t it);
		int gap;
		gap = 0;
		while ($urandom_range(99) < tx_idle) gap++;
		if (gap > 0) begin
			item_valid <= 0;
			repeat (gap) @(posedge clk);
		end
		item_valid <= 1;
		item <= it;
		do @(posedge clk); while (item_stall);
		sb.note_item(it);
	endtask

	task automatic write_reg(cfg_idx_t idx, bit [23:0] d);
		wr_en <= 1;
		wr_index <= idx;
		wr_data <= d;
		@(posedge clk);
		sb.set_reg(idx, d);
	endtask

	task automatic configure(bit [23:0] tr, bit [23:0] al, bit [23:0] gn, bit [23:0] off);
		write_reg(CFG_TARGET, tr);
		write_reg(CFG_ALPHA, al);
		write_reg(CFG_GAIN_NUM, gn);
		write_reg(CFG_T0, off);
		wr_en <= 0;
	endtask

	// drain all results, then let an empty end-of-run item finish too
	task automatic drain();
		item_valid <= 0;
		while (sb.pending_q.size() != 0) @(posedge clk);
		repeat (120) @(posedge clk);
	endtask

	function automatic bit [31:0] pick_width();
		case ($urandom_range(3))
			0: return $urandom_range(131071);
			1: return $urandom_range(1) ? 32'hFFFF_FFFF : 32'h0;
			default: return $urandom;
		endcase
	endfunction

	function automatic bit [15:0] pick_level();
		case ($urandom_range(7))
			0: return 16'h0000;
			1: return 16'hFFFF;
			default: return 16'($urandom);
		endcase
	endfunction

	// one run of widths for a group; an empty run when len is zero
	task automatic send_run(int g, bit [15:0] acc, int len, inout int sent);
		item_t it;
		it.group_index = 6'(g);
		it.acceptance_level = acc;
		if (len == 0) begin
			it.width_value = $urandom;
			it.value_present = 1'b0;
			it.last_element = 1'b1;
			send_item(it);
			sent++;
			return;
		end
		for (int k = 0; k < len; k++) begin
			// later items of a run sometimes carry another group and level
			if (k > 0 && $urandom_range(3) == 0) begin
				it.group_index = 6'($urandom);
				it.acceptance_level = 16'($urandom);
			end
			it.width_value = pick_width();
			it.value_present = 1'b1;
			it.last_element = (k == len - 1);
			send_item(it);
			sent++;
		end
	endtask

	task automatic random_items(int n);
		int sent;
		item_t it;
		sent = 0;
		while (sent < n) begin
			if ($urandom_range(9) == 0) begin
				// noise: widthless non-last item or a fully random one
				it = 56'({$urandom, $urandom});
				if ($urandom_range(1)) it.value_present = 1'b0;
				if (!it.value_present) it.last_element = 1'b0;
				send_item(it);
				sent++;
			end else begin
				send_run($urandom_range(63), pick_level(), $urandom_range(0, 5), sent);
			end
		end
	endtask

	initial begin
		int sent;
		item_t it;
		arst_n = 0;
		item_valid = 0;
		item = '0;
		result_stall = 0;
		wr_en = 0;
		wr_index = CFG_TARGET;
		wr_data = '0;
		tx_idle = 6;
		rx_idle = 51;
		sb = new();
		repeat (6) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		sent = 0;

		// directed: reset settings, field extremes, empty runs, ignored items
		send_run(0, 16'h0000, 1, sent);
		send_run(63, 16'hFFFF, 2, sent);
		it = '0;
		it.group_index = 6'd7;
		send_item(it);
		send_run(5, 16'd15335, 0, sent);
		send_run(5, 16'h8000, 3, sent);
		send_run(0, 16'h0001, 4, sent);
		send_run(63, 16'hFFFF, 1, sent);
		drain();

		// extremes: target low, alpha one, largest gain numerator, zero offset
		configure(24'd1, 24'd65536, 24'hFF_FFFF, 24'd0);
		send_run(20, 16'h0000, 2, sent);
		send_run(21, 16'hFFFF, 2, sent);
		random_items(110);
		drain();

		// other extremes: target high, alpha just over a half, zero numerator
		configure(24'd65535, 24'd32769, 24'd0, 24'hFF_FFFF);
		send_run(20, 16'h0000, 3, sent);
		random_items(110);
		drain();

		tx_idle = 51;
		rx_idle = 6;
		// values beyond the documented ranges
		configure(24'd0, 24'h1_FFFF, 24'd1, 24'd1);
		random_items(110);
		drain();
		configure(24'($urandom_range(1, 65535)), 24'($urandom_range(32769, 65536)),
			24'($urandom_range(1, 24'hFF_FFFF)), 24'($urandom_range(0, 4096)));
		random_items(110);
		drain();

		tx_idle = 0;
		rx_idle = 0;
		configure(24'(TARGET_RST), 24'(ALPHA_RST), GNUM_RST, T0_RST);
		random_items(110);
		drain();
		configure(24'($urandom), 24'($urandom), 24'($urandom), 24'($urandom));
		random_items(110);
		drain();

		if (sb.mismatches == 0 && sb.pending_q.size() == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
